FILE: rtl/bump_arena_allocator_top_macros.svh
// Assertion macros for the bump arena allocator.
// Both macros sample on clk_i and hold off while rst_ni is low.
`ifndef BUMP_ARENA_ALLOCATOR_TOP_MACROS_SVH
`define BUMP_ARENA_ALLOCATOR_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BAA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BAA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/baa_pkg.sv
// ----------------------------------------------------------------------------
// baa_pkg
// Types and constants shared by the bump arena allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package baa_pkg;

  localparam logic [31:0] ALIGN_LIMIT = 32'hFFFF_FFF8;
  localparam logic [31:0] SUM_MAX     = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_REALLOC = 2'd2,
    CMD_RESET   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_NOT_RECLAIMED = 3'd1,
    ST_OOM           = 3'd2,
    ST_OVERFLOW      = 3'd3,
    ST_BAD_PARAM     = 3'd4,
    ST_BAD_STATE     = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALIGN,
    S_TEST,
    S_EXEC,
    S_RESP
  } state_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] buffer_offset;
    logic        buffer_present;
    logic [31:0] held_size;
    logic [31:0] want_size;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] result_offset;
    logic        result_present;
    logic [31:0] bytes_in_use;
    logic [31:0] shortfall_total;
  } rsp_t;

  // Step enables from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic align;
    logic test;
    logic exec;
  } ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/baa_ctrl.sv
// ----------------------------------------------------------------------------
// baa_ctrl
// Command sequencer: walks each accepted item through align, test and
// execute steps, then strobes the result for one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module baa_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output baa_pkg::ctrl_t      ctrl_o,
  output logic                busy,
  output logic                done_o
);

  baa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= baa_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      baa_pkg::S_IDLE:  if (start) state_d = baa_pkg::S_ALIGN;
      baa_pkg::S_ALIGN: state_d = baa_pkg::S_TEST;
      baa_pkg::S_TEST:  state_d = baa_pkg::S_EXEC;
      baa_pkg::S_EXEC:  state_d = baa_pkg::S_RESP;
      baa_pkg::S_RESP:  state_d = baa_pkg::S_IDLE;
      default:          state_d = baa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    busy   = 1'b1;
    done_o = 1'b0;
    unique case (state_q)
      baa_pkg::S_IDLE: begin
        busy        = 1'b0;
        ctrl_o.load = start;
      end
      baa_pkg::S_ALIGN: ctrl_o.align = 1'b1;
      baa_pkg::S_TEST:  ctrl_o.test  = 1'b1;
      baa_pkg::S_EXEC:  ctrl_o.exec  = 1'b1;
      baa_pkg::S_RESP:  done_o       = 1'b1;
      default:          busy         = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/baa_datapath.sv
// ----------------------------------------------------------------------------
// baa_datapath
// Holds the capacity, bump index and shortfall total, and computes one
// command over three registered steps.
// ----------------------------------------------------------------------------
`default_nettype none

module baa_datapath (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire baa_pkg::ctrl_t ctrl_i,
  input  wire baa_pkg::req_t  req_i,
  input  wire logic           cfg_we_i,
  input  wire logic [31:0]    cfg_data_i,
  output baa_pkg::rsp_t       rsp_o
);

  baa_pkg::req_t req_q;
  baa_pkg::rsp_t rsp_q, rsp_d;
  logic [31:0]   cap_q;
  logic [31:0]   idx_q, idx_d;
  logic [31:0]   sum_q, sum_d;

  // align step
  logic [31:0] na_q, oa_q, room_q;
  logic        nov_q, oov_q;
  // test step
  logic        tail_q, lt_q, same_q;
  logic [31:0] grow_q, shrink_q;

  logic [31:0] cap_al;
  logic [32:0] tail_sum;
  logic [31:0] need, dec_amt, inc_val, dec_val, sat_sum;
  logic [32:0] sum_wide;
  logic        short, cap0, is_free;

  assign cap_al = {cap_q[31:3], 3'b000};
  assign cap0   = (cap_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= '0;
      idx_q <= '0;
      sum_q <= '0;
    end else begin
      if (cfg_we_i) cap_q <= cfg_data_i;
      if (ctrl_i.exec) begin
        idx_q <= idx_d;
        sum_q <= sum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) req_q <= req_i;
    if (ctrl_i.align) begin
      nov_q  <= req_q.want_size > baa_pkg::ALIGN_LIMIT;
      oov_q  <= req_q.held_size > baa_pkg::ALIGN_LIMIT;
      na_q   <= (req_q.want_size + 32'd7) & ~32'd7;
      oa_q   <= (req_q.held_size + 32'd7) & ~32'd7;
      room_q <= (cap_al > idx_q) ? cap_al - idx_q : '0;
      same_q <= req_q.held_size == req_q.want_size;
    end
    if (ctrl_i.test) begin
      tail_q   <= req_q.buffer_present && (oa_q != '0) && (tail_sum == {1'b0, idx_q});
      lt_q     <= na_q < oa_q;
      grow_q   <= na_q - oa_q;
      shrink_q <= oa_q - na_q;
    end
    if (ctrl_i.exec) rsp_q <= rsp_d;
  end

  assign tail_sum = {1'b0, req_q.buffer_offset} + {1'b0, oa_q};

  // Growth of a tail block needs only the extra bytes; everything else needs na.
  assign need     = (req_q.cmd == baa_pkg::CMD_REALLOC && tail_q) ? grow_q : na_q;
  assign short    = room_q < need;
  assign sum_wide = {1'b0, sum_q} + {1'b0, need};
  assign sat_sum  = sum_wide[32] ? baa_pkg::SUM_MAX : sum_wide[31:0];
  assign inc_val  = idx_q + need;
  assign is_free  = (req_q.cmd == baa_pkg::CMD_FREE) || (na_q == '0);
  assign dec_amt  = is_free ? oa_q : shrink_q;
  assign dec_val  = idx_q - dec_amt;

  always_comb begin
    rsp_d                = '0;
    idx_d                = idx_q;
    sum_d                = sum_q;
    rsp_d.status         = baa_pkg::ST_OK;
    unique case (req_q.cmd)
      baa_pkg::CMD_ALLOC: begin
        priority if (req_q.want_size == '0) begin
          rsp_d.status = baa_pkg::ST_BAD_PARAM;
        end else if (cap0) begin
          rsp_d.status = baa_pkg::ST_BAD_STATE;
        end else if (nov_q) begin
          rsp_d.status = baa_pkg::ST_OVERFLOW;
        end else if (short) begin
          rsp_d.status = baa_pkg::ST_OOM;
          sum_d        = sat_sum;
        end else begin
          rsp_d.result_offset  = idx_q;
          rsp_d.result_present = 1'b1;
          idx_d                = inc_val;
        end
      end
      baa_pkg::CMD_FREE: begin
        priority if (cap0) begin
          rsp_d.status = baa_pkg::ST_BAD_STATE;
        end else if (oov_q) begin
          rsp_d.status = baa_pkg::ST_OVERFLOW;
        end else if (tail_q) begin
          idx_d = dec_val;
        end else begin
          rsp_d.status = baa_pkg::ST_NOT_RECLAIMED;
        end
      end
      baa_pkg::CMD_REALLOC: begin
        rsp_d.result_present = req_q.buffer_present;
        rsp_d.result_offset  = req_q.buffer_present ? req_q.buffer_offset : '0;
        priority if (nov_q || oov_q) begin
          rsp_d.status = baa_pkg::ST_OVERFLOW;
        end else if (na_q == '0) begin
          // zero new size: behave as free of the old block
          priority if (cap0) begin
            rsp_d.status = baa_pkg::ST_BAD_STATE;
          end else if (tail_q) begin
            idx_d                = dec_val;
            rsp_d.result_present = 1'b0;
            rsp_d.result_offset  = '0;
          end else begin
            rsp_d.status = baa_pkg::ST_NOT_RECLAIMED;
          end
        end else if (req_q.buffer_present && same_q) begin
          rsp_d.status = baa_pkg::ST_OK;
        end else if (cap0) begin
          rsp_d.status = baa_pkg::ST_BAD_STATE;
        end else if (tail_q) begin
          priority if (lt_q) begin
            idx_d = dec_val;
          end else if (short) begin
            rsp_d.status = baa_pkg::ST_OOM;
            sum_d        = sat_sum;
          end else begin
            idx_d = inc_val;
          end
        end else if (!lt_q && (na_q != oa_q)) begin
          // buried block grows: hand out a fresh block
          if (short) begin
            rsp_d.status = baa_pkg::ST_OOM;
            sum_d        = sat_sum;
          end else begin
            rsp_d.status         = baa_pkg::ST_NOT_RECLAIMED;
            rsp_d.result_present = 1'b1;
            rsp_d.result_offset  = idx_q;
            idx_d                = inc_val;
          end
        end else begin
          rsp_d.status = baa_pkg::ST_NOT_RECLAIMED;
        end
      end
      baa_pkg::CMD_RESET: idx_d = '0;
      default:            idx_d = idx_q;
    endcase
    rsp_d.bytes_in_use    = idx_d;
    rsp_d.shortfall_total = sum_d;
  end

  assign rsp_o = rsp_q;

endmodule

`default_nettype wire

FILE: rtl/bump_arena_allocator_top.sv
// ----------------------------------------------------------------------------
// bump_arena_allocator_top
// Bump-pointer arena allocator: alloc, free, realloc and arena reset commands
// over byte offsets, sizes rounded up to multiples of 8.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Each command goes
// through three datapath steps (size rounding and free room, tail test, update
// of index and shortfall total), then done_o strobes the result on rsp_o for
// exactly one cycle, and the block is free again in the cycle after. The
// receiver cannot stall; capture rsp_o whenever done_o is high. Write
// arena_capacity through cfg_valid_i/cfg_ready_o while busy is low.
`default_nettype none

module bump_arena_allocator_top (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire baa_pkg::req_t req_i,
  output logic               done_o,
  output baa_pkg::rsp_t      rsp_o,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [31:0]   cfg_data_i
);

`include "bump_arena_allocator_top_macros.svh"

  baa_pkg::ctrl_t ctrl;

  assign cfg_ready_o = !busy;

  baa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .ctrl_o (ctrl),
    .busy   (busy),
    .done_o (done_o)
  );

  baa_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .req_i      (req_i),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .rsp_o      (rsp_o)
  );

  `BAA_ASSERT_SAME(a_done_busy, done_o, busy, "result strobe outside a command")
  `BAA_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done_o, "accepted command not started")
  `BAA_ASSERT_NEXT(a_done_single, done_o, !done_o && !busy, "result strobe longer than a cycle")
  `BAA_ASSERT_NEXT(a_busy_hold, busy && !done_o, busy, "command dropped before its result")
  `BAA_ASSERT_SAME(a_status_range, done_o, rsp_o.status <= baa_pkg::ST_BAD_STATE, "bad status code")

endmodule

`default_nettype wire
